// ===== hdl/csvfs_pkg.sv =====
// ----------------------------------------------------------------------------
// CSV field splitter package
// Shared types, character constants and parser mode codes.
// ----------------------------------------------------------------------------
`default_nettype none

package csvfs_pkg;

   // Characters with a fixed meaning to the parser.
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   // Reset value of the separator register (comma).
   localparam logic [7:0] SEPARATOR_RESET = 8'h2C;

   // Configuration space.
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_ADDR_SEPARATOR = 3'd0;

   // Parser mode codes.
   localparam logic [2:0] MODE_START  = 3'd0;  // at the start of a field
   localparam logic [2:0] MODE_PLAIN  = 3'd1;  // inside an unquoted field
   localparam logic [2:0] MODE_QUOTED = 3'd2;  // inside quotes
   localparam logic [2:0] MODE_QSEEN  = 3'd3;  // quote seen inside quotes
   localparam logic [2:0] MODE_CLOSED = 3'd4;  // quoted field closed
   localparam logic [2:0] MODE_SKIP   = 3'd5;  // dropping bytes up to LF

   typedef struct packed {
      logic [7:0] byte_value;
      logic       is_end;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       field_end;
      logic       record_end;
      logic       format_error;
   } rsp_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       record_pending;
      logic       any_byte_seen;
   } parse_state_type;

endpackage : csvfs_pkg

`default_nettype wire

// ===== hdl/csvfs_decode.sv =====
// ----------------------------------------------------------------------------
// CSV field splitter byte decoder
// Decides one byte: next parser state and the optional result.
// ----------------------------------------------------------------------------
`default_nettype none

module csvfs_decode (
   input  wire csvfs_pkg::parse_state_type state_cur,
   input  wire csvfs_pkg::req_type         req_item,
   input  wire logic [7:0]                 separator,
   output csvfs_pkg::parse_state_type      state_nxt,
   output csvfs_pkg::rsp_type              rsp_item,
   output logic                            rsp_emit
);
   import csvfs_pkg::*;

   logic [7:0] b;
   logic       is_sep;
   logic       is_eol;
   logic       is_delim;
   rsp_type    delim_rsp;
   rsp_type    data_rsp;
   rsp_type    err_rsp;
   parse_state_type delim_state;

   assign b        = req_item.byte_value;
   assign is_sep   = (b == separator);
   assign is_eol   = (b == CHAR_LF) || (b == CHAR_CR);
   assign is_delim = is_sep || is_eol;

   // Separator takes precedence over CR and LF when they coincide.
   always_comb begin
      delim_rsp              = '0;
      delim_rsp.field_end    = 1'b1;
      delim_rsp.record_end   = !is_sep;
      delim_state.any_byte_seen = 1'b1;
      if (is_sep) begin
         delim_state.mode           = MODE_START;
         delim_state.record_pending = 1'b1;
      end else begin
         delim_state.mode           = (b == CHAR_CR) ? MODE_SKIP : MODE_START;
         delim_state.record_pending = 1'b0;
      end
   end

   always_comb begin
      data_rsp           = '0;
      data_rsp.data_byte = b;
      data_rsp.has_byte  = 1'b1;
      err_rsp              = '0;
      err_rsp.format_error = 1'b1;
   end

   always_comb begin
      state_nxt               = state_cur;
      state_nxt.any_byte_seen = 1'b1;
      rsp_item                = '0;
      rsp_emit                = 1'b0;
      if (req_item.is_end) begin
         state_nxt = '0;
         if (state_cur.record_pending || !state_cur.any_byte_seen) begin
            rsp_emit                = 1'b1;
            rsp_item.field_end      = 1'b1;
            rsp_item.record_end     = 1'b1;
            rsp_item.format_error   = (state_cur.mode == MODE_QUOTED);
         end
      end else begin
         unique case (state_cur.mode)
            MODE_PLAIN: begin
               rsp_emit = 1'b1;
               if (is_delim) begin
                  state_nxt = delim_state;
                  rsp_item  = delim_rsp;
               end else begin
                  rsp_item  = data_rsp;
               end
            end
            MODE_QUOTED: begin
               if (b == CHAR_QUOTE) begin
                  state_nxt.mode = MODE_QSEEN;
               end else begin
                  rsp_emit = 1'b1;
                  rsp_item = data_rsp;
               end
            end
            MODE_QSEEN: begin
               rsp_emit = 1'b1;
               if (b == CHAR_QUOTE) begin
                  // A doubled quote is one literal quote.
                  rsp_item       = data_rsp;
                  state_nxt.mode = MODE_QUOTED;
               end else if (is_delim) begin
                  state_nxt = delim_state;
                  rsp_item  = delim_rsp;
               end else begin
                  rsp_item       = err_rsp;
                  state_nxt.mode = MODE_CLOSED;
               end
            end
            MODE_CLOSED: begin
               rsp_emit = 1'b1;
               if (is_delim) begin
                  state_nxt = delim_state;
                  rsp_item  = delim_rsp;
               end else begin
                  rsp_item  = err_rsp;
               end
            end
            MODE_SKIP: begin
               if (b == CHAR_LF) begin
                  state_nxt.mode = MODE_START;
               end
            end
            default: begin
               // Field start; the unused codes behave the same way.
               rsp_emit = 1'b1;
               if (is_delim) begin
                  state_nxt = delim_state;
                  rsp_item  = delim_rsp;
               end else if (b == CHAR_QUOTE) begin
                  rsp_emit                 = 1'b0;
                  state_nxt.record_pending = 1'b1;
                  state_nxt.mode           = MODE_QUOTED;
               end else begin
                  rsp_item                 = data_rsp;
                  state_nxt.record_pending = 1'b1;
                  state_nxt.mode           = MODE_PLAIN;
               end
            end
         endcase
      end
   end

endmodule : csvfs_decode

`default_nettype wire

// ===== hdl/csv_field_splitter_unit.sv =====
// ----------------------------------------------------------------------------
// CSV field splitter
// Splits a CSV byte stream into field bytes, field ends and record ends.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Payload
//   req_      in         req_valid/ready    byte_value, is_end
//   rsp_      out        rsp_valid/ready    data_byte, has_byte, field_end,
//                                           record_end, format_error
//   config    in         APB psel/penable   separator at byte address 0
//
// A request is captured in an input register, decoded in the following cycle
// and its result, if any, enters the result register once that is free.
// The decoder sees only the parser state and one byte, so the block sustains
// one request per cycle while the result side does not stall. A result is
// presented from the result register. A request that makes no result simply
// retires out of the input register. When the result register is full and not
// being taken and the waiting request makes a result, the input register holds
// that request and req_ready stays low for as long as the result side stalls.
// Synchronous reset clears both valid flags and the parser state and returns
// the separator to SEPARATOR_INIT, a comma by default.
//
`default_nettype none

module csv_field_splitter_unit #(
   parameter logic [7:0] SEPARATOR_INIT = csvfs_pkg::SEPARATOR_RESET
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // Request channel
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire csvfs_pkg::req_type                     req_data,
   // Result channel
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output csvfs_pkg::rsp_type                          rsp_data,
   // Configuration port
   input  wire logic                                   psel,
   input  wire logic                                   penable,
   input  wire logic                                   pwrite,
   input  wire logic [csvfs_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  wire logic [csvfs_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [csvfs_pkg::CSR_DATA_WIDTH-1:0]        prdata,
   output logic                                        pready
);
   import csvfs_pkg::*;

   // Separator register, written through the configuration port.
   logic [7:0] separator_ff;
   logic [7:0] separator_in;
   logic       csr_write;

   // Input register.
   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_item_ff;

   // Parser state.
   parse_state_type state_ff;
   parse_state_type state_nxt;

   // Result register.
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_item_ff;

   // Decoder outputs.
   rsp_type dec_rsp;
   logic    dec_emit;

   logic out_free;
   logic advance;
   logic req_take;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr == CSR_ADDR_SEPARATOR);
   assign separator_in = csr_write ? pwdata[7:0] : separator_ff;

   always_comb begin
      prdata = '0;
      if (paddr == CSR_ADDR_SEPARATOR) begin
         prdata[7:0] = separator_ff;
      end
   end

   csvfs_decode u_decode (
      .state_cur (state_ff),
      .req_item  (in_item_ff),
      .separator (separator_ff),
      .state_nxt (state_nxt),
      .rsp_item  (dec_rsp),
      .rsp_emit  (dec_emit)
   );

   // The result register can take a new result when it is empty or being
   // drained this cycle. A request with no result never waits for it.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (out_free || !dec_emit);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = (advance && dec_emit) || (out_valid_ff && !rsp_ready);

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff <= SEPARATOR_INIT;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         separator_ff <= separator_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_nxt;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_data;
      end
      if (advance && dec_emit) begin
         out_item_ff <= dec_rsp;
      end
   end

endmodule : csv_field_splitter_unit

`default_nettype wire
